FILE: rtl/rcfd_pkg.sv
// Shared types, constants and helper functions of the remote-control frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  // Frame geometry
  localparam int FRAME_LEN   = 18;
  localparam int POS_W       = 5;
  localparam int NUM_KEYS    = 18;
  localparam int THR_W       = 16;
  localparam int CH_W        = 11;
  localparam int MOUSE_W     = 16;
  localparam int LIMIT_W     = 15;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TDATA_W     = 128;
  localparam int DEF_COUNTER_WIDTH = 16;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_THR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_THR    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MOUSE_LIMIT  = 3'd4;

  // Reset values
  localparam logic [THR_W-1:0]   RST_DEBOUNCE_THR = 16'd5;
  localparam logic [THR_W-1:0]   RST_SHORT_THR    = 16'd3;
  localparam logic [CH_W-1:0]    RST_CHANNEL_LOW  = 11'd364;
  localparam logic [CH_W-1:0]    RST_CHANNEL_HIGH = 11'd1684;
  localparam logic [LIMIT_W-1:0] RST_MOUSE_LIMIT  = 15'd25000;
  localparam logic [CH_W-1:0]    CH_CENTER        = 11'd1024;
  localparam logic [1:0]         RST_SWITCH       = 2'd3;

  // Stick deadband, exclusive bounds
  localparam logic [CH_W-1:0] DEAD_LO = 11'd1020;
  localparam logic [CH_W-1:0] DEAD_HI = 11'd1028;

  // Mouse button byte value that means pressed
  localparam logic [7:0] BUTTON_DOWN = 8'd1;

  typedef enum logic [1:0] {
    STYLE_LATCH,
    STYLE_PULSE,
    STYLE_TOGGLE,
    STYLE_AUTO
  } key_style_e;

  typedef enum logic [1:0] {
    THR_MAIN,
    THR_SHORT,
    THR_ONE
  } thr_sel_e;

  // Per-key debounce style: W S A D shift ctrl Q E R F G Z X C V B, mouse left, right
  localparam key_style_e KEY_STYLE [NUM_KEYS] = '{
    STYLE_LATCH, STYLE_LATCH, STYLE_LATCH, STYLE_LATCH,
    STYLE_AUTO, STYLE_AUTO,
    STYLE_PULSE, STYLE_TOGGLE,
    STYLE_AUTO,
    STYLE_LATCH, STYLE_LATCH, STYLE_LATCH,
    STYLE_LATCH, STYLE_LATCH,
    STYLE_LATCH, STYLE_LATCH,
    STYLE_AUTO, STYLE_AUTO
  };

  localparam thr_sel_e KEY_THR [NUM_KEYS] = '{
    THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN,
    THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN, THR_MAIN,
    THR_SHORT, THR_SHORT, THR_MAIN, THR_MAIN, THR_ONE, THR_MAIN
  };

  // Thresholds handed to the debouncers
  typedef struct packed {
    logic [THR_W-1:0] thr_main;
    logic [THR_W-1:0] thr_short;
  } key_cfg_t;

  // Snap a stick value inside the deadband to center
  function automatic logic [CH_W-1:0] snap_stick(logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = ((c > DEAD_LO) && (c < DEAD_HI)) ? CH_CENTER : c;
    return r;
  endfunction

  // Clamp a signed mouse axis to plus or minus the limit
  function automatic logic [MOUSE_W-1:0] clamp_mouse(logic [MOUSE_W-1:0] raw,
                                                     logic [LIMIT_W-1:0] lim);
    logic signed [MOUSE_W:0] v;
    logic signed [MOUSE_W:0] l;
    logic signed [MOUSE_W:0] r;
    v = signed'({raw[MOUSE_W-1], raw});
    l = signed'({2'b00, lim});
    r = v;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end
    return r[MOUSE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rcfd_debounce.sv
// Bank of key debouncers with per-key latch, pulse, toggle and auto-reset styles.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_debounce #(
  parameter int COUNTER_WIDTH = rcfd_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           update_i,
  input  wire logic [rcfd_pkg::NUM_KEYS-1:0]  pressed_i,
  input  wire rcfd_pkg::key_cfg_t             cfg_i,
  output logic      [rcfd_pkg::NUM_KEYS-1:0]  flags_o
);
  import rcfd_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt_q [NUM_KEYS];
  logic [COUNTER_WIDTH-1:0] cnt_d [NUM_KEYS];
  logic [NUM_KEYS-1:0]      flags_q;
  logic [NUM_KEYS-1:0]      flags_d;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic [THR_W-1:0]         thr;
    logic [COUNTER_WIDTH-1:0] inc;
    logic                     hit;

    // Pick this key's threshold
    always_comb begin
      unique case (KEY_THR[k])
        THR_MAIN:  thr = cfg_i.thr_main;
        THR_SHORT: thr = cfg_i.thr_short;
        default:   thr = THR_W'(1);
      endcase
    end

    assign inc = cnt_q[k] + COUNTER_WIDTH'(1);
    assign hit = (THR_W'(inc) == thr);

    // Advance count and flag by style
    always_comb begin
      cnt_d[k]   = cnt_q[k];
      flags_d[k] = flags_q[k];
      if (pressed_i[k]) begin
        cnt_d[k] = inc;
        unique case (KEY_STYLE[k])
          STYLE_LATCH:  if (hit) flags_d[k] = 1'b1;
          STYLE_PULSE:  flags_d[k] = hit;
          STYLE_TOGGLE: if (hit) flags_d[k] = ~flags_q[k];
          STYLE_AUTO: begin
            if (hit) begin
              flags_d[k] = 1'b1;
              cnt_d[k]   = '0;
            end
          end
        endcase
      end else begin
        if (KEY_STYLE[k] != STYLE_AUTO) cnt_d[k] = '0;
        if (KEY_STYLE[k] != STYLE_TOGGLE) flags_d[k] = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[k] <= '0;
      end else if (update_i) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (update_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

FILE: rtl/rc_receiver_frame_decoder.sv
// Top level: frame byte capture, decode, range check and held output values.
// The byte marked tlast sets a pending decode; the frame is decoded once the
// output register is free, and the result is registered onto the master side.
// Throughput: one byte per cycle; a pending decode stalls input only while the
// output transaction is held by the sink.
// Reset: asynchronous, active low; sticks and wheel go to center, switches to 3,
// mouse, key flags and counters to zero, registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module rc_receiver_frame_decoder #(
  parameter int COUNTER_WIDTH = rcfd_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Slave side
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,  // rx_byte
  input  wire logic                               s_axis_tlast,  // frame_end
  // Master side
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // stick_right_h, stick_right_v, stick_left_h, stick_left_v, switch_left,
  // switch_right, wheel, mouse_dx, mouse_dy, mouse_dz, key_flags, zero pad
  output logic [rcfd_pkg::TDATA_W-1:0]            m_axis_tdata,
  output logic                                    m_axis_tuser,  // frame_valid
  // Configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [rcfd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [rcfd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import rcfd_pkg::*;

  // Configuration registers
  logic [THR_W-1:0]   dbn_thr_q;
  logic [THR_W-1:0]   short_thr_q;
  logic [CH_W-1:0]    ch_low_q;
  logic [CH_W-1:0]    ch_high_q;
  logic [LIMIT_W-1:0] mouse_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbn_thr_q   <= RST_DEBOUNCE_THR;
      short_thr_q <= RST_SHORT_THR;
      ch_low_q    <= RST_CHANNEL_LOW;
      ch_high_q   <= RST_CHANNEL_HIGH;
      mouse_lim_q <= RST_MOUSE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DEBOUNCE_THR: dbn_thr_q   <= cfg_wdata_i;
        REG_SHORT_THR:    short_thr_q <= cfg_wdata_i;
        REG_CHANNEL_LOW:  ch_low_q    <= cfg_wdata_i[CH_W-1:0];
        REG_CHANNEL_HIGH: ch_high_q   <= cfg_wdata_i[CH_W-1:0];
        REG_MOUSE_LIMIT:  mouse_lim_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic in_acc;
  logic pend_q;
  logic pend_d;
  logic len_ok_q;
  logic len_ok_d;
  logic pend_fire;
  logic out_valid_q;
  logic out_valid_d;

  assign pend_fire     = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || pend_fire;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Byte capture
  logic [7:0]       frame_q [FRAME_LEN];
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_d;

  always_ff @(posedge clk_i) begin
    if (in_acc && (pos_q < POS_W'(FRAME_LEN))) begin
      frame_q[pos_q] <= s_axis_tdata;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    pend_d   = pend_q && !pend_fire;
    len_ok_d = len_ok_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        pos_d    = '0;
        pend_d   = 1'b1;
        len_ok_d = (pos_q == POS_LAST);
      end else if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pend_q   <= 1'b0;
      len_ok_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      len_ok_q <= len_ok_d;
    end
  end

  // Unpack the stored frame
  logic [CH_W-1:0]    ch [4];
  logic [1:0]         sw_l;
  logic [1:0]         sw_r;
  logic [CH_W-1:0]    wheel_raw;
  logic [MOUSE_W-1:0] mx_raw;
  logic [MOUSE_W-1:0] my_raw;
  logic [MOUSE_W-1:0] mz_raw;
  logic [NUM_KEYS-1:0] pressed;
  logic [3:0]          ch_ok;
  logic                frame_ok;
  logic                upd;

  always_comb begin
    ch[0]     = {frame_q[1][2:0], frame_q[0]};
    ch[1]     = {frame_q[2][5:0], frame_q[1][7:3]};
    ch[2]     = {frame_q[4][0], frame_q[3], frame_q[2][7:6]};
    ch[3]     = {frame_q[5][3:0], frame_q[4][7:1]};
    sw_l      = frame_q[5][7:6];
    sw_r      = frame_q[5][5:4];
    mx_raw    = {frame_q[7], frame_q[6]};
    my_raw    = {frame_q[9], frame_q[8]};
    mz_raw    = {frame_q[11], frame_q[10]};
    wheel_raw = {frame_q[17][2:0], frame_q[16]};
    pressed   = {frame_q[13] == BUTTON_DOWN, frame_q[12] == BUTTON_DOWN,
                 frame_q[15], frame_q[14]};
  end

  // Range check; sticks compared against both limits
  for (genvar i = 0; i < 4; i++) begin : g_chk
    assign ch_ok[i] = (ch[i] >= ch_low_q) && (ch[i] <= ch_high_q);
  end

  assign frame_ok = len_ok_q && (&ch_ok) && (sw_l != '0) && (sw_r != '0);
  assign upd      = pend_fire && frame_ok;

  // Held values double as the output register
  logic [CH_W-1:0]    stick_q [4];
  logic [CH_W-1:0]    wheel_q;
  logic [1:0]         sw_l_q;
  logic [1:0]         sw_r_q;
  logic [MOUSE_W-1:0] mx_q;
  logic [MOUSE_W-1:0] my_q;
  logic [MOUSE_W-1:0] mz_q;
  logic               fvalid_q;
  logic [NUM_KEYS-1:0] key_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) stick_q[i] <= CH_CENTER;
      wheel_q <= CH_CENTER;
      sw_l_q  <= RST_SWITCH;
      sw_r_q  <= RST_SWITCH;
      mx_q    <= '0;
      my_q    <= '0;
      mz_q    <= '0;
    end else if (upd) begin
      for (int i = 0; i < 4; i++) stick_q[i] <= snap_stick(ch[i]);
      wheel_q <= wheel_raw;
      sw_l_q  <= sw_l;
      sw_r_q  <= sw_r;
      mx_q    <= clamp_mouse(mx_raw, mouse_lim_q);
      my_q    <= clamp_mouse(my_raw, mouse_lim_q);
      mz_q    <= mz_raw;
    end
  end

  key_cfg_t key_cfg;
  assign key_cfg.thr_main  = dbn_thr_q;
  assign key_cfg.thr_short = short_thr_q;

  rcfd_debounce #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_debounce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (upd),
    .pressed_i (pressed),
    .cfg_i     (key_cfg),
    .flags_o   (key_flags)
  );

  // Output transaction valid and accept flag
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (pend_fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fvalid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pend_fire) fvalid_q <= frame_ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = fvalid_q;
  assign m_axis_tdata  = {3'b000, key_flags, mz_q, my_q, mx_q, wheel_q, sw_r_q, sw_l_q,
                          stick_q[3], stick_q[2], stick_q[1], stick_q[0]};

`ifndef ASSERT_OFF
  // A new output transaction only follows a pending decode
  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("output valid without pending decode");

  // An accepted frame always carries nonzero switches
  a_valid_switches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> ((sw_l_q != '0) && (sw_r_q != '0)))
    else $error("accepted frame with zero switch");

  // The byte marked last restarts the position count
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (pos_q == '0) && pend_q)
    else $error("position not restarted after last byte");
`endif

endmodule

`default_nettype wire

FILE: test/rcfd_frame_checker.sv
// Checker for the remote-control frame decoder: mirrors the decode and debounce, compares results.
`timescale 1ns / 1ps

module rcfd_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [7:0]                      s_tdata_i,   // rx_byte
  input  logic                            s_tlast_i,   // frame_end
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // stick_right_h, stick_right_v, stick_left_h, stick_left_v, switch_left,
  // switch_right, wheel, mouse_dx, mouse_dy, mouse_dz, key_flags, zero pad
  input  logic [rcfd_pkg::TDATA_W-1:0]    m_tdata_i,
  input  logic                            m_tuser_i,   // frame_valid
  input  logic                            cfg_we_i,
  input  logic [rcfd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              pending_o,
  output int                              fail_count_o
);
  import rcfd_pkg::*;

  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   right_h;
    logic [CH_W-1:0]   right_v;
    logic [CH_W-1:0]   left_h;
    logic [CH_W-1:0]   left_v;
    logic [1:0]        sw_left;
    logic [1:0]        sw_right;
    logic [CH_W-1:0]   wheel;
    logic [MOUSE_W-1:0] dx;
    logic [MOUSE_W-1:0] dy;
    logic [MOUSE_W-1:0] dz;
    logic [NUM_KEYS-1:0] keys;
  } frame_result_t;

  // Register mirror
  logic [THR_W-1:0]   thr_main;
  logic [THR_W-1:0]   thr_short;
  logic [CH_W-1:0]    lim_lo;
  logic [CH_W-1:0]    lim_hi;
  logic [LIMIT_W-1:0] mouse_lim;

  // Decoder state mirror
  logic [7:0]          frame_buf [FRAME_LEN];
  logic [POS_W-1:0]    byte_pos;
  logic [CH_W-1:0]     stick_hold [4];
  logic [CH_W-1:0]     wheel_hold;
  logic [1:0]          sw_hold [2];
  logic [MOUSE_W-1:0]  mouse_hold [3];
  logic [THR_W-1:0]    press_cnt [NUM_KEYS];
  logic [NUM_KEYS-1:0] flag_hold;

  frame_result_t frame_results_q [$];
  int fail_tally = 0;

  assign fail_count_o = fail_tally;

  function automatic logic [CH_W-1:0] center_snap(logic [CH_W-1:0] c);
    return ((c > DEAD_LO) && (c < DEAD_HI)) ? CH_CENTER : c;
  endfunction

  function automatic logic [MOUSE_W-1:0] limit_axis(logic [MOUSE_W-1:0] raw);
    logic signed [MOUSE_W:0] v;
    logic signed [MOUSE_W:0] lim;
    v   = {raw[MOUSE_W-1], raw};
    lim = {2'b00, mouse_lim};
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v[MOUSE_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    frame_result_t       want;
    frame_result_t       got;
    logic [47:0]         hdr;
    logic [CH_W-1:0]     ch [4];
    logic [1:0]          s1;
    logic [1:0]          s2;
    logic [NUM_KEYS-1:0] pressed;
    logic [THR_W-1:0]    cnt;
    logic [THR_W-1:0]    thr;
    logic                hit;
    logic                ok;
    int                  i;
    int                  k;

    if (!rst_ni) begin
      thr_main  = RST_DEBOUNCE_THR;
      thr_short = RST_SHORT_THR;
      lim_lo    = RST_CHANNEL_LOW;
      lim_hi    = RST_CHANNEL_HIGH;
      mouse_lim = RST_MOUSE_LIMIT;
      byte_pos  = '0;
      for (i = 0; i < FRAME_LEN; i++) frame_buf[i] = '0;
      for (i = 0; i < 4; i++) stick_hold[i] = CH_CENTER;
      wheel_hold = CH_CENTER;
      sw_hold[0] = RST_SWITCH;
      sw_hold[1] = RST_SWITCH;
      for (i = 0; i < 3; i++) mouse_hold[i] = '0;
      for (i = 0; i < NUM_KEYS; i++) press_cnt[i] = '0;
      flag_hold = '0;
      frame_results_q.delete();
      pending_o <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_DEBOUNCE_THR: thr_main  = cfg_wdata_i;
          REG_SHORT_THR:    thr_short = cfg_wdata_i;
          REG_CHANNEL_LOW:  lim_lo    = cfg_wdata_i[CH_W-1:0];
          REG_CHANNEL_HIGH: lim_hi    = cfg_wdata_i[CH_W-1:0];
          REG_MOUSE_LIMIT:  mouse_lim = cfg_wdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result transaction with the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        if (frame_results_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_tally++;
        end else begin
          want = frame_results_q.pop_front();
          got.valid    = m_tuser_i;
          got.right_h  = m_tdata_i[10:0];
          got.right_v  = m_tdata_i[21:11];
          got.left_h   = m_tdata_i[32:22];
          got.left_v   = m_tdata_i[43:33];
          got.sw_left  = m_tdata_i[45:44];
          got.sw_right = m_tdata_i[47:46];
          got.wheel    = m_tdata_i[58:48];
          got.dx       = m_tdata_i[74:59];
          got.dy       = m_tdata_i[90:75];
          got.dz       = m_tdata_i[106:91];
          got.keys     = m_tdata_i[124:107];
          check_field("frame_valid", want.valid, got.valid);
          check_field("stick_right_h", want.right_h, got.right_h);
          check_field("stick_right_v", want.right_v, got.right_v);
          check_field("stick_left_h", want.left_h, got.left_h);
          check_field("stick_left_v", want.left_v, got.left_v);
          check_field("switch_left", want.sw_left, got.sw_left);
          check_field("switch_right", want.sw_right, got.sw_right);
          check_field("wheel", want.wheel, got.wheel);
          check_field("mouse_dx", want.dx, got.dx);
          check_field("mouse_dy", want.dy, got.dy);
          check_field("mouse_dz", want.dz, got.dz);
          check_field("key_flags", want.keys, got.keys);
        end
      end

      // Capture an accepted byte; decode on the frame end
      if (s_tvalid_i && s_tready_i) begin
        if (byte_pos < FRAME_LEN) frame_buf[byte_pos] = s_tdata_i;
        if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
        if (s_tlast_i) begin
          ok = 1'b0;
          if (byte_pos == FRAME_LEN) begin
            hdr = {frame_buf[5], frame_buf[4], frame_buf[3],
                   frame_buf[2], frame_buf[1], frame_buf[0]};
            ch[0] = hdr[10:0];
            ch[1] = hdr[21:11];
            ch[2] = hdr[32:22];
            ch[3] = hdr[43:33];
            s1    = hdr[47:46];
            s2    = hdr[45:44];
            ok = (s1 != 2'd0) && (s2 != 2'd0);
            for (i = 0; i < 4; i++) begin
              if (ch[i] < lim_lo || ch[i] > lim_hi) ok = 1'b0;
            end
          end
          if (ok) begin
            for (i = 0; i < 4; i++) stick_hold[i] = center_snap(ch[i]);
            wheel_hold    = {frame_buf[17][2:0], frame_buf[16]};
            sw_hold[0]    = s1;
            sw_hold[1]    = s2;
            mouse_hold[0] = limit_axis({frame_buf[7], frame_buf[6]});
            mouse_hold[1] = limit_axis({frame_buf[9], frame_buf[8]});
            mouse_hold[2] = {frame_buf[11], frame_buf[10]};
            pressed = {frame_buf[13] == BUTTON_DOWN, frame_buf[12] == BUTTON_DOWN,
                       frame_buf[15], frame_buf[14]};

            // Step every key debouncer in its own style
            for (k = 0; k < NUM_KEYS; k++) begin
              case (KEY_THR[k])
                THR_MAIN:  thr = thr_main;
                THR_SHORT: thr = thr_short;
                default:   thr = THR_W'(1);
              endcase
              if (pressed[k]) begin
                cnt = press_cnt[k] + 1'b1;
                hit = (cnt == thr);
                case (KEY_STYLE[k])
                  STYLE_LATCH:  if (hit) flag_hold[k] = 1'b1;
                  STYLE_PULSE:  flag_hold[k] = hit;
                  STYLE_TOGGLE: if (hit) flag_hold[k] = ~flag_hold[k];
                  default: begin
                    if (hit) begin
                      flag_hold[k] = 1'b1;
                      cnt = '0;
                    end
                  end
                endcase
                press_cnt[k] = cnt;
              end else begin
                if (KEY_STYLE[k] != STYLE_AUTO) press_cnt[k] = '0;
                if (KEY_STYLE[k] != STYLE_TOGGLE) flag_hold[k] = 1'b0;
              end
            end
          end
          byte_pos = '0;

          want.valid    = ok;
          want.right_h  = stick_hold[0];
          want.right_v  = stick_hold[1];
          want.left_h   = stick_hold[2];
          want.left_v   = stick_hold[3];
          want.sw_left  = sw_hold[0];
          want.sw_right = sw_hold[1];
          want.wheel    = wheel_hold;
          want.dx       = mouse_hold[0];
          want.dy       = mouse_hold[1];
          want.dz       = mouse_hold[2];
          want.keys     = flag_hold;
          frame_results_q.push_back(want);
        end
      end
      pending_o <= frame_results_q.size();
    end
  end

endmodule

FILE: test/tb.sv
// Testbench top for the remote-control frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import rcfd_pkg::*;

  localparam int ITEM_TARGET    = 1850;
  localparam int NUM_PHASES     = 11;
  localparam int SINK_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER [5] = '{
    REG_DEBOUNCE_THR, REG_SHORT_THR, REG_CHANNEL_LOW, REG_CHANNEL_HIGH, REG_MOUSE_LIMIT
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [TDATA_W-1:0]    m_tdata;
  wire                   m_tuser;
  int                    pending;
  int                    fail_count;

  // Stimulus-side view of the window and clamp, used to aim stick and mouse values
  logic [CH_W-1:0]       win_lo = RST_CHANNEL_LOW;
  logic [CH_W-1:0]       win_hi = RST_CHANNEL_HIGH;
  logic [LIMIT_W-1:0]    cur_mouse_lim = RST_MOUSE_LIMIT;
  logic [NUM_KEYS-1:0]   key_state = '0;
  int                    bytes_sent = 0;
  int                    sender_calm = 0;
  int                    sink_calm = 0;
  int                    idle_cycles = 0;

  rc_receiver_frame_decoder DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  rcfd_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int random_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CH_W-1:0] pick_stick();
    int v;
    if (win_lo <= win_hi && $urandom_range(9, 0) != 0) begin
      case ($urandom_range(3, 0))
        0: v = $urandom_range(1, 0) ? win_lo : win_hi;
        1: begin
          // aim around the deadband
          v = $urandom_range(1030, 1018);
          if (v < win_lo) v = win_lo;
          if (v > win_hi) v = win_hi;
        end
        default: v = $urandom_range(win_hi, win_lo);
      endcase
    end else begin
      v = $urandom_range(2047, 0);
    end
    return CH_W'(v);
  endfunction

  function automatic logic [MOUSE_W-1:0] pick_axis();
    int r;
    int off;
    r = $urandom_range(5, 0);
    if (r == 0) return $urandom_range(1, 0) ? 16'h8000 : 16'h7fff;
    if (r == 1) begin
      // just inside, on, or just past the clamp
      off = int'(cur_mouse_lim) + int'($urandom_range(4, 0)) - 2;
      if ($urandom_range(1, 0)) off = -off;
      return MOUSE_W'(off);
    end
    return MOUSE_W'($urandom_range(65535, 0));
  endfunction

  // Offer one byte and hold it until the block takes it
  task automatic put_byte(input logic [7:0] b, input logic last);
    int n;
    if (sender_calm > 0) begin
      sender_calm--;
      n = 0;
    end else begin
      n = random_gap();
      if ($urandom_range(39, 0) == 0) sender_calm = $urandom_range(40, 10);
    end
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [4*CH_W-1:0] sticks, input logic [1:0] sw_l,
                            input logic [1:0] sw_r, input logic [15:0] mx,
                            input logic [15:0] my, input logic [15:0] mz,
                            input logic [7:0] btn_l, input logic [7:0] btn_r,
                            input logic [15:0] keys, input logic [15:0] whl);
    logic [7:0]  fb [FRAME_LEN];
    logic [47:0] hdr;
    int          i;
    hdr = {sw_l, sw_r, sticks};
    for (i = 0; i < 6; i++) fb[i] = hdr[8*i +: 8];
    fb[6]  = mx[7:0];
    fb[7]  = mx[15:8];
    fb[8]  = my[7:0];
    fb[9]  = my[15:8];
    fb[10] = mz[7:0];
    fb[11] = mz[15:8];
    fb[12] = btn_l;
    fb[13] = btn_r;
    fb[14] = keys[7:0];
    fb[15] = keys[15:8];
    fb[16] = whl[7:0];
    fb[17] = whl[15:8];
    for (i = 0; i < FRAME_LEN; i++) put_byte(fb[i], i == FRAME_LEN - 1);
  endtask

  // Well-formed frame; keys are held over many frames so the debouncers reach threshold
  task automatic send_random_frame();
    logic [1:0] sw [2];
    logic [7:0] btn [2];
    int         j;
    if ($urandom_range(3, 0) == 0) key_state ^= NUM_KEYS'($urandom & $urandom & $urandom);
    if ($urandom_range(24, 0) == 0) key_state = NUM_KEYS'($urandom);
    for (j = 0; j < 2; j++) begin
      sw[j] = ($urandom_range(11, 0) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
      if (key_state[16 + j]) btn[j] = BUTTON_DOWN;
      else if ($urandom_range(3, 0) == 0) btn[j] = 8'($urandom_range(255, 2));
      else btn[j] = 8'd0;
    end
    send_frame({pick_stick(), pick_stick(), pick_stick(), pick_stick()}, sw[0], sw[1],
               pick_axis(), pick_axis(), MOUSE_W'($urandom_range(65535, 0)),
               btn[0], btn[1], key_state[15:0], 16'($urandom_range(65535, 0)));
  endtask

  // Random bytes; the last one closes the run, others may too when scattered
  task automatic send_junk(input int n, input bit scatter);
    int i;
    for (i = 0; i < n; i++) begin
      put_byte(8'($urandom_range(255, 0)),
               (i == n - 1) || (scatter && $urandom_range(3, 0) == 0));
    end
  endtask

  // Stop offering and let every pending result drain
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] d_thr, input logic [15:0] s_thr,
                              input logic [10:0] lo, input logic [10:0] hi,
                              input logic [14:0] ml);
    logic [CFG_DATA_W-1:0] vals [5];
    int                    i;
    vals = '{d_thr, 16'(lo) & 16'h0, 16'(lo), 16'(hi), 16'(ml)};
    vals[1] = s_thr;
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    win_lo = lo;
    win_hi = hi;
    cur_mouse_lim = ml;
  endtask

  // Sink: random stalls, plus long hold-offs that back the block up
  initial begin : sink
    int n;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 40 || taken == 150) begin
        n = SINK_HOLD;
      end else if (sink_calm > 0) begin
        sink_calm--;
        n = 0;
      end else begin
        n = random_gap();
        if ($urandom_range(39, 0) == 0) sink_calm = $urandom_range(40, 10);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL rc_receiver_frame_decoder");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin : stim
    int phase;
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short frames, then a full frame at the window edges and axis extremes
    put_byte(8'hff, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5a, 1'b1);
    send_frame({11'd1027, 11'd1021, 11'd1684, 11'd364}, 2'd1, 2'd3,
               16'h8000, 16'h7fff, 16'h8000, BUTTON_DOWN, 8'hff, 16'hffff, 16'hffff);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: write_config(16'd1, 16'd1, 11'd0, 11'd2047, 15'd0);
          2: write_config(16'd65535, 16'd65535, 11'd1021, 11'd1027, 15'd32767);
          // inverted window: nothing is accepted
          3: write_config(16'd3, 16'd2, 11'd1500, 11'd400, 15'd100);
          // zero threshold only matches on counter wrap
          4: write_config(16'd0, 16'd1, 11'd364, 11'd1684, 15'd1);
          5: write_config(16'd2, 16'd1, 11'd2047, 11'd2047, 15'd32767);
          6: write_config(16'd1, 16'd2, 11'd0, 11'd0, 15'd12345);
          default: write_config(16'($urandom_range(6, 1)), 16'($urandom_range(4, 1)),
                                11'($urandom_range(1020, 0)),
                                11'($urandom_range(2047, 1028)),
                                15'($urandom_range(32767, 0)));
        endcase
      end
      while (bytes_sent < (phase + 1) * ITEM_TARGET / NUM_PHASES) begin
        r = $urandom_range(99, 0);
        if (r < 78) send_random_frame();
        else if (r < 86) send_junk($urandom_range(17, 1), 1'b0);
        else if (r < 92) send_junk($urandom_range(40, 19), 1'b0);
        else send_junk($urandom_range(8, 1), 1'b1);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS rc_receiver_frame_decoder");
    end else begin
      $display("FAIL rc_receiver_frame_decoder");
    end
    $finish;
  end

endmodule
